>>> rtl/core/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

   // Fixed field widths
   localparam int OFF_W    = 24;
   localparam int LEN_W    = 25;
   localparam int NEED_W   = 29;
   localparam int ADDR_W   = 32;
   localparam int COUNT_W  = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] POOL_LIMIT = 25'h100_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE = 2'd1;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE    = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDRESS = 2'd2;
   localparam logic [1:0] STATUS_TABLE_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INIT,
      OP_ALLOC_EXACT,
      OP_ALLOC_SPLIT,
      OP_FREE
   } op_code_type;

   // One segment entry held by a cell
   typedef struct packed {
      logic             valid;
      logic             is_free;
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] length;
   } seg_type;

   // Search key broadcast to all cells during a scan
   typedef struct packed {
      logic              is_free_cmd;
      logic [NEED_W-1:0] need;
      logic              tgt_ok;
      logic [OFF_W-1:0]  tgt;
   } key_type;

   // Update broadcast to all cells in the action cycle
   typedef struct packed {
      op_code_type      code;
      logic [LEN_W-1:0] length;
      logic             merge_left;
      logic             merge_right;
   } op_type;

   // Token that walks the chain one cell per cycle
   typedef struct packed {
      logic             live;
      logic             found;
      logic             left_free;
      logic             right_free;
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] left_length;
      logic [LEN_W-1:0] right_length;
   } tok_type;

endpackage
`default_nettype wire

>>> rtl/core/ffsa_cell.sv
// One cell of the segment chain: holds a segment, checks the passing token, applies updates.
`default_nettype none
module ffsa_cell #(
   parameter bit IS_HEAD = 1'b0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ffsa_pkg::key_type key,
   input  wire ffsa_pkg::op_type  op,
   input  wire ffsa_pkg::seg_type left,
   input  wire ffsa_pkg::seg_type right1,
   input  wire ffsa_pkg::seg_type right2,
   input  wire logic             left_win,
   input  wire logic             right_win,
   input  wire ffsa_pkg::tok_type tok_in,
   output ffsa_pkg::tok_type      tok_out,
   output ffsa_pkg::seg_type      seg_out,
   output logic                  win_out
);
   import ffsa_pkg::*;

   seg_type    seg_ff, seg_in;
   tok_type    tok_ff, tok_in_next;
   logic       win_ff, win_in;
   logic       after_ff, after_in;
   logic       hit;
   logic [1:0] shift;
   logic       is_merge_head;
   logic       moves;

   // Does this segment satisfy the search key
   always_comb begin
      if (key.is_free_cmd) begin
         hit = seg_ff.valid && key.tgt_ok && (seg_ff.offset == key.tgt);
      end else begin
         hit = seg_ff.valid && seg_ff.is_free &&
               ({{(NEED_W-LEN_W){1'b0}}, seg_ff.length} >= key.need);
      end
   end

   // Token pass-through; first hit records itself and its neighbors
   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.live && !tok_in.found && hit) begin
         tok_in_next.found        = 1'b1;
         tok_in_next.offset       = seg_ff.offset;
         tok_in_next.length       = seg_ff.length;
         tok_in_next.left_length  = left.length;
         tok_in_next.right_length = right1.length;
         tok_in_next.left_free    = left.valid && left.is_free;
         tok_in_next.right_free   = right1.valid && right1.is_free;
      end
   end

   // Winner and follower flags, refreshed as the token goes by
   always_comb begin
      win_in   = win_ff;
      after_in = after_ff;
      if (tok_in.live) begin
         win_in   = !tok_in.found && hit;
         after_in = tok_in.found;
      end
   end

   // Segment update
   always_comb begin
      shift         = {1'b0, op.merge_left} + {1'b0, op.merge_right};
      is_merge_head = op.merge_left ? right_win : win_ff;
      moves         = (op.merge_left ? (win_ff || after_ff) : after_ff) && (shift != 2'd0);
      seg_in        = seg_ff;
      case (op.code)
         OP_INIT: begin
            seg_in.valid   = IS_HEAD;
            seg_in.is_free = IS_HEAD;
            seg_in.offset  = '0;
            seg_in.length  = IS_HEAD ? op.length : '0;
         end
         OP_ALLOC_EXACT: begin
            if (win_ff) begin
               seg_in.is_free = 1'b0;
            end
         end
         OP_ALLOC_SPLIT: begin
            if (win_ff) begin
               seg_in.is_free = 1'b0;
               seg_in.length  = op.length;
            end else if (after_ff) begin
               if (left_win) begin
                  seg_in.valid   = 1'b1;
                  seg_in.is_free = 1'b1;
                  seg_in.offset  = left.offset + op.length[OFF_W-1:0];
                  seg_in.length  = left.length - op.length;
               end else begin
                  seg_in = left;
               end
            end
         end
         OP_FREE: begin
            if (is_merge_head) begin
               seg_in.is_free = 1'b1;
               seg_in.length  = op.length;
            end else if (moves) begin
               seg_in = (shift == 2'd1) ? right1 : right2;
            end
         end
         default: begin
            seg_in = seg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid   <= IS_HEAD;
         seg_ff.is_free <= IS_HEAD;
         seg_ff.offset  <= '0;
         seg_ff.length  <= '0;
         tok_ff         <= '0;
         win_ff         <= 1'b0;
         after_ff       <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         tok_ff   <= tok_in_next;
         win_ff   <= win_in;
         after_ff <= after_in;
      end
   end

   assign tok_out = tok_ff;
   assign seg_out = seg_ff;
   assign win_out = win_ff;

endmodule
`default_nettype wire

>>> rtl/core/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: control, registers and the cell chain.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_valid / req_stall | req_cmd, req_elem_count, req_free_address
//  rsp     | out       | rsp_valid / rsp_stall | rsp_granted_address, rsp_status
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
//  The search token walks the chain one cell per cycle; its exit from the last cell
//  is captured into the result register, and the update is applied in ST_ACT.
//  Reset leaves an empty pool held as one free segment of length zero.
//  A result waits in the output register while rsp_stall is high; the update
//  cycle holds until that register is free. csr writes are taken while idle.
`default_nettype none
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ELEM_BYTES   = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic [ffsa_pkg::COUNT_W-1:0]     req_elem_count,
   input  wire logic [ffsa_pkg::ADDR_W-1:0]      req_free_address,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [ffsa_pkg::ADDR_W-1:0]           rsp_granted_address,
   output logic [1:0]                            rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ffsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ffsa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ffsa_pkg::*;

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   key_type              key_ff, key_in;
   logic                 start_ff, start_in;
   tok_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 act_done;
   logic [ADDR_W-1:0]    diff;
   logic [LEN_W-1:0]     need_lo;
   logic [LEN_W-1:0]     rest;
   logic [LEN_W-1:0]     total;
   logic [1:0]           dec_status;
   logic [ADDR_W-1:0]    dec_addr;
   op_type               dec_op;
   op_type               cell_op;
   logic [LEN_W-1:0]     size_sat;

   seg_type              segs [MAX_SEGMENTS];
   tok_type              toks [MAX_SEGMENTS];
   logic                 wins [MAX_SEGMENTS];
   tok_type              tok_head;
   tok_type              tok_last;

   assign req_xfer = req_valid && !req_stall;
   assign csr_xfer = csr_valid && csr_ready;
   assign act_done = (state_ff == ST_ACT) && (!rsp_valid_ff || !rsp_stall);
   assign tok_last = toks[MAX_SEGMENTS-1];

   // Cell chain
   always_comb begin
      tok_head      = '0;
      tok_head.live = start_ff;
   end

   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      seg_type left_seg, right1_seg, right2_seg;
      logic    left_w, right_w;
      tok_type tin;
      if (g == 0) begin : g_head
         assign left_seg = '0;
         assign left_w   = 1'b0;
         assign tin      = tok_head;
      end else begin : g_mid
         assign left_seg = segs[g-1];
         assign left_w   = wins[g-1];
         assign tin      = toks[g-1];
      end
      if (g + 1 < MAX_SEGMENTS) begin : g_r1
         assign right1_seg = segs[g+1];
         assign right_w    = wins[g+1];
      end else begin : g_r1_end
         assign right1_seg = '0;
         assign right_w    = 1'b0;
      end
      if (g + 2 < MAX_SEGMENTS) begin : g_r2
         assign right2_seg = segs[g+2];
      end else begin : g_r2_end
         assign right2_seg = '0;
      end
      ffsa_cell #(
         .IS_HEAD (g == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key_ff),
         .op        (cell_op),
         .left      (left_seg),
         .right1    (right1_seg),
         .right2    (right2_seg),
         .left_win  (left_w),
         .right_win (right_w),
         .tok_in    (tin),
         .tok_out   (toks[g]),
         .seg_out   (segs[g]),
         .win_out   (wins[g])
      );
   end

   // Request decode at accept
   always_comb begin
      diff               = req_free_address - base_ff;
      key_in             = key_ff;
      key_in.is_free_cmd = (req_cmd == CMD_FREE);
      key_in.need        = NEED_W'(req_elem_count) * NEED_W'(ELEM_BYTES);
      key_in.tgt_ok      = (diff[ADDR_W-1:OFF_W] == '0);
      key_in.tgt         = diff[OFF_W-1:0];
   end

   // Result decision from the captured token
   always_comb begin
      need_lo    = key_ff.need[LEN_W-1:0];
      rest       = res_ff.length - need_lo;
      total      = (res_ff.left_free ? res_ff.left_length : '0) + res_ff.length +
                   (res_ff.right_free ? res_ff.right_length : '0);
      dec_status = STATUS_OK;
      dec_addr   = '0;
      dec_op     = '0;
      dec_op.code = OP_NONE;
      if (key_ff.is_free_cmd) begin
         if (!res_ff.found) begin
            dec_status = STATUS_BAD_ADDRESS;
         end else begin
            dec_op.code        = OP_FREE;
            dec_op.length      = total;
            dec_op.merge_left  = res_ff.left_free;
            dec_op.merge_right = res_ff.right_free;
         end
      end else if (!res_ff.found || (key_ff.need == '0)) begin
         dec_status = STATUS_NO_SPACE;
      end else if ((rest != '0) && (count_ff == CNT_MAX)) begin
         dec_status = STATUS_TABLE_FULL;
      end else begin
         dec_addr      = base_ff + ADDR_W'(res_ff.offset);
         dec_op.length = need_lo;
         dec_op.code   = (rest != '0) ? OP_ALLOC_SPLIT : OP_ALLOC_EXACT;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_last.live) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if (act_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs and the cell update
   always_comb begin
      size_sat = (csr_data[LEN_W-1:0] > POOL_LIMIT) ? POOL_LIMIT : csr_data[LEN_W-1:0];
      req_stall = (state_ff != ST_IDLE);
      csr_ready = (state_ff == ST_IDLE);
      cell_op   = '0;
      cell_op.code = OP_NONE;
      if (csr_xfer && (csr_index == CSR_POOL_SIZE)) begin
         cell_op.code   = OP_INIT;
         cell_op.length = size_sat;
      end else if (act_done) begin
         cell_op = dec_op;
      end
   end

   // Register next values
   always_comb begin
      base_in       = base_ff;
      count_in      = count_ff;
      start_in      = req_xfer;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (csr_xfer && (csr_index == CSR_POOL_BASE)) begin
         base_in = csr_data;
      end
      case (cell_op.code)
         OP_INIT:        count_in = CNT_W'(1);
         OP_ALLOC_SPLIT: count_in = count_ff + CNT_W'(1);
         OP_FREE:        count_in = count_ff - CNT_W'(cell_op.merge_left) -
                                    CNT_W'(cell_op.merge_right);
         default:        count_in = count_ff;
      endcase
      if ((state_ff == ST_SCAN) && tok_last.live) begin
         res_in = tok_last;
      end
      if (act_done) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = dec_addr;
         rsp_status_in = dec_status;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= CNT_W'(1);
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         key_ff <= key_in;
      end
      res_ff        <= res_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_MAX))
      else $error("segment count out of range");

   a_token_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && tok_last.live |=> (state_ff == ST_ACT))
      else $error("token exit not followed by update cycle");

   a_rsp_from_act: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ACT))
      else $error("result raised outside update cycle");

   a_token_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_last.live |-> (state_ff == ST_SCAN))
      else $error("token left the chain outside a scan");

endmodule
`default_nettype wire

>>> dv/first_fit_segment_allocator_test.sv
// Self-checking testbench of the first-fit segment allocator against a segment-table predictor.
`timescale 1ns / 1ps
module first_fit_segment_allocator_test;
   import ffsa_pkg::*;

   localparam int MAX_SEGS  = 64;
   localparam int LATENCY   = MAX_SEGS + 3;
   localparam int WDOG_MAX  = 20000;

   typedef struct {
      logic [ADDR_W-1:0] granted;
      logic [1:0]        status;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = CMD_ALLOC;
   logic [COUNT_W-1:0] req_elem_count = '0;
   logic [ADDR_W-1:0] req_free_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_granted_address;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POOL_BASE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predicted allocator state
   logic [OFF_W-1:0]  seg_off [MAX_SEGS];
   logic [LEN_W-1:0]  seg_len [MAX_SEGS];
   bit                seg_free [MAX_SEGS];
   int                seg_cnt;
   logic [ADDR_W-1:0] base_addr;
   logic [LEN_W-1:0]  pool_bytes;

   grant_type pending_grants[$];
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int idle_cycles = 0;
   bit idling_on = 1'b1;
   int hold_left = 0;
   int burst_left = 0;
   int seen_status[4] = '{0, 0, 0, 0};

   always #4 clock = ~clock;

   first_fit_segment_allocator dut (.*);

   // Table reinit on pool size write
   function automatic void table_reinit();
      for (int k = 0; k < MAX_SEGS; k++) begin
         seg_off[k] = '0;
         seg_len[k] = '0;
         seg_free[k] = 1'b0;
      end
      seg_len[0] = pool_bytes;
      seg_free[0] = 1'b1;
      seg_cnt = 1;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      logic [LEN_W-1:0] v;
      v = val[LEN_W-1:0];
      if (idx == CSR_POOL_BASE) begin
         base_addr = val;
      end else if (idx == CSR_POOL_SIZE) begin
         pool_bytes = (v > POOL_LIMIT) ? POOL_LIMIT : v;
         table_reinit();
      end
   endfunction

   // Merge adjacent free segments
   function automatic void coalesce();
      int i;
      i = 0;
      while (i + 1 < seg_cnt) begin
         if (seg_free[i] && seg_free[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            for (int k = i + 1; k + 1 < seg_cnt; k++) begin
               seg_off[k] = seg_off[k+1];
               seg_len[k] = seg_len[k+1];
               seg_free[k] = seg_free[k+1];
            end
            seg_cnt--;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic grant_type predict_grant(logic cmd, logic [COUNT_W-1:0] count,
                                               logic [ADDR_W-1:0] addr);
      grant_type g;
      logic [NEED_W-1:0] need;
      logic [LEN_W-1:0] rest;
      g.granted = '0;
      g.status = STATUS_NO_SPACE;
      need = NEED_W'(count) * NEED_W'(4);
      if (cmd == CMD_ALLOC) begin
         if (need == 0) return g;
         for (int i = 0; i < seg_cnt; i++) begin
            if (seg_free[i] && NEED_W'(seg_len[i]) >= need) begin
               rest = seg_len[i] - need[LEN_W-1:0];
               if (rest != 0) begin
                  if (seg_cnt >= MAX_SEGS) begin
                     g.status = STATUS_TABLE_FULL;
                     return g;
                  end
                  for (int k = seg_cnt; k > i + 1; k--) begin
                     seg_off[k] = seg_off[k-1];
                     seg_len[k] = seg_len[k-1];
                     seg_free[k] = seg_free[k-1];
                  end
                  seg_off[i+1] = seg_off[i] + need[OFF_W-1:0];
                  seg_len[i+1] = rest;
                  seg_free[i+1] = 1'b1;
                  seg_cnt++;
                  seg_len[i] = need[LEN_W-1:0];
               end
               seg_free[i] = 1'b0;
               g.granted = base_addr + ADDR_W'(seg_off[i]);
               g.status = STATUS_OK;
               return g;
            end
         end
      end else begin
         g.status = STATUS_BAD_ADDRESS;
         for (int i = 0; i < seg_cnt; i++) begin
            if (base_addr + ADDR_W'(seg_off[i]) == addr) begin
               seg_free[i] = 1'b1;
               coalesce();
               g.status = STATUS_OK;
               return g;
            end
         end
      end
      return g;
   endfunction

   // One request transfer, with an optional random gap ahead of it
   task automatic send_request(logic cmd, logic [COUNT_W-1:0] count, logic [ADDR_W-1:0] addr);
      int gap;
      gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_elem_count <= count;
      req_free_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_grants.push_back(predict_grant(cmd, count, addr));
      sent++;
   endtask

   task automatic send_alloc(logic [COUNT_W-1:0] count);
      send_request(CMD_ALLOC, count, $urandom);
   endtask

   task automatic send_free(logic [ADDR_W-1:0] addr);
      send_request(CMD_FREE, COUNT_W'($urandom), addr);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup_pool(logic [ADDR_W-1:0] pbase, logic [CSR_DATA_W-1:0] psize);
      wait_drained();
      write_csr(CSR_POOL_BASE, pbase);
      write_csr(CSR_POOL_SIZE, psize);
   endtask

   // Address of a live table entry, or a random one
   function automatic logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 9) < 7)
         return base_addr + ADDR_W'(seg_off[$urandom_range(0, seg_cnt - 1)]);
      return $urandom;
   endfunction

   // Empty pool straight out of reset
   task automatic test_reset_pool();
      send_alloc(1);
      send_free('0);
      send_free(32'hFFFF_FFFF);
   endtask

   // Split, exact fit, double free, bad address, zero and oversized counts
   task automatic test_basic_ops();
      logic [ADDR_W-1:0] a0;
      setup_pool(32'h1000_0000, 256);
      send_alloc(0);
      send_alloc(1);
      a0 = base_addr + ADDR_W'(seg_off[0]);
      send_alloc(3);
      send_free(a0);
      send_free(a0);
      send_free(a0 + 2);
      send_alloc(1);
      send_alloc(60);
      send_alloc(23'h7F_FFFF);
      send_alloc(1);
      send_free(32'h1000_0010);
   endtask

   // Fill the table, then hit table full and an exact fit while full
   task automatic test_table_full();
      setup_pool(32'h0000_0F00, 1024);
      for (int n = 0; n < MAX_SEGS - 1; n++) send_alloc(1);
      send_alloc(1);
      send_alloc(193);
      send_alloc(1);
      send_free(32'h0000_0F04);
      send_alloc(1);
   endtask

   // Largest pool, saturating size writes and address wrap
   task automatic test_pool_extremes();
      setup_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_alloc(23'h40_0000);
      send_alloc(1);
      send_free(32'hFFFF_FFFF);
      send_alloc(23'h3F_FFFF);
      send_alloc(1);
      send_alloc(1);
      setup_pool(32'h0, 32'h0100_0001);
      send_alloc(23'h40_0000);
      setup_pool(32'h8000_0000, 0);
      send_alloc(1);
      send_free(32'h8000_0000);
   endtask

   // Mostly well-formed alloc/free traffic with some noise
   task automatic test_random_traffic(int items, logic [CSR_DATA_W-1:0] psize);
      setup_pool($urandom, psize);
      for (int n = 0; n < items; n++) begin
         case ($urandom_range(0, 9))
            0: send_alloc(COUNT_W'($urandom));
            1, 2, 3, 4: send_alloc(COUNT_W'($urandom_range(1, 24)));
            5: send_alloc(COUNT_W'($urandom_range(1, (pool_bytes >> 2) + 1)));
            default: send_free(pick_address());
         endcase
      end
   endtask

   // Receiver holds off while requests keep coming, then sender waits for drain
   task automatic test_backpressure();
      setup_pool(32'h0002_0000, 512);
      @(posedge clock);
      hold_left = 400;
      for (int n = 0; n < 20; n++) send_alloc(COUNT_W'($urandom_range(1, 8)));
      wait_drained();
      for (int n = 0; n < 10; n++) send_free(pick_address());
   endtask

   // Result checker and receiver stall generator
   always @(posedge clock) begin
      grant_type exp_grant;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            seen_status[rsp_status]++;
            if (pending_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: addr %h status %0d",
                           rsp_granted_address, rsp_status);
            end else begin
               exp_grant = pending_grants.pop_front();
               if (rsp_granted_address !== exp_grant.granted ||
                   rsp_status !== exp_grant.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected addr %h status %0d, got addr %h status %0d",
                              checked, exp_grant.granted, exp_grant.status,
                              rsp_granted_address, rsp_status);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(0, 13);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      base_addr = '0;
      pool_bytes = '0;
      table_reinit();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_pool();
      test_basic_ops();
      test_table_full();
      test_pool_extremes();
      test_backpressure();
      test_random_traffic(120, 256);
      test_random_traffic(120, 1024);
      test_random_traffic(60, $urandom_range(4, 4096));
      idling_on = 1'b0;
      test_random_traffic(100, 512);
      wait_drained();
      $display("Sent %0d requests, checked %0d results: ok %0d, no_space %0d,",
               sent, checked, seen_status[0], seen_status[1]);
      $display("bad_address %0d, table_full %0d; %0d mismatches",
               seen_status[2], seen_status[3], mismatches);
      if (mismatches == 0 && pending_grants.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
